>>> sv/pds_pkg.sv
// shared types, constants and hex helpers for the percent decoder stream core
`default_nettype none

package pds_pkg;

    // escape marker and digit characters
    localparam logic [7:0] PDS_PCT_CHAR = 8'h25;
    localparam logic [7:0] PDS_CHR_0    = 8'h30;
    localparam logic [7:0] PDS_CHR_9    = 8'h39;
    localparam logic [7:0] PDS_CHR_UA   = 8'h41;
    localparam logic [7:0] PDS_CHR_UF   = 8'h46;
    localparam logic [7:0] PDS_CHR_LA   = 8'h61;
    localparam logic [7:0] PDS_CHR_LF   = 8'h66;
    localparam logic [3:0] PDS_DIGIT_TEN_M1 = 4'd9;

    // result group geometry
    localparam int PDS_MAX_OUT = 3;
    localparam int PDS_IDX_W   = 2;

    // queue between front and back
    localparam int PDS_FIFO_DEPTH = 4;
    localparam int PDS_PTR_W      = $clog2(PDS_FIFO_DEPTH);
    localparam int PDS_CNT_W      = $clog2(PDS_FIFO_DEPTH + 1);

    // what the front holds back between items
    typedef enum logic [1:0] {
        HOLD_NONE      = 2'd0,
        HOLD_PCT       = 2'd1,
        HOLD_PCT_DIGIT = 2'd2
    } pds_hold_t;

    // one group of decoded bytes caused by one input item
    typedef struct packed {
        logic [PDS_MAX_OUT-1:0][7:0] data;
        logic [PDS_IDX_W-1:0]        cnt;
        logic                        last;
    } pds_entry_t;

    function automatic logic pds_is_hex(input logic [7:0] c);
        logic dec;
        logic up;
        logic lo;
        dec = (c >= PDS_CHR_0) && (c <= PDS_CHR_9);
        up  = (c >= PDS_CHR_UA) && (c <= PDS_CHR_UF);
        lo  = (c >= PDS_CHR_LA) && (c <= PDS_CHR_LF);
        return dec || up || lo;
    endfunction

    // value of a byte already known to be a hex digit
    function automatic logic [3:0] pds_hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c <= PDS_CHR_9)
        begin
            v = c[3:0];
        end
        else
        begin
            v = c[3:0] + PDS_DIGIT_TEN_M1;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> sv/pds_front.sv
// front part: classifies each input item and builds its group of output bytes
`default_nettype none

module pds_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output logic               push,
    output pds_pkg::pds_entry_t entry
);
    import pds_pkg::*;

    pds_hold_t   hold_reg;
    pds_hold_t   hold_next;
    logic [7:0]  digit_reg;
    logic [7:0]  digit_next;
    logic        b_hex;
    logic        b_pct_wait;
    logic [7:0]  decoded;

    assign b_hex      = pds_is_hex(in_byte);
    assign b_pct_wait = (in_byte == PDS_PCT_CHAR) && !in_last;
    assign decoded    = {pds_hex_val(digit_reg), pds_hex_val(in_byte)};

    // held state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= HOLD_NONE;
        end
        else if (accept)
        begin
            hold_reg <= hold_next;
        end
    end

    // held digit payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            digit_reg <= digit_next;
        end
    end

    // next held state
    always_comb
    begin
        hold_next  = HOLD_NONE;
        digit_next = digit_reg;
        case (hold_reg)
            HOLD_NONE:
            begin
                if (b_pct_wait)
                begin
                    hold_next = HOLD_PCT;
                end
            end
            HOLD_PCT:
            begin
                if (b_hex && !in_last)
                begin
                    hold_next  = HOLD_PCT_DIGIT;
                    digit_next = in_byte;
                end
                else if (!b_hex && b_pct_wait)
                begin
                    hold_next = HOLD_PCT;
                end
            end
            default:
            begin
                if (!b_hex && b_pct_wait)
                begin
                    hold_next = HOLD_PCT;
                end
            end
        endcase
    end

    // output byte group for this item
    always_comb
    begin
        entry.data = '0;
        entry.cnt  = '0;
        entry.last = in_last;
        case (hold_reg)
            HOLD_NONE:
            begin
                entry.data[0] = in_byte;
                entry.cnt     = b_pct_wait ? 2'd0 : 2'd1;
            end
            HOLD_PCT:
            begin
                entry.data[0] = PDS_PCT_CHAR;
                entry.data[1] = in_byte;
                if (b_hex)
                begin
                    entry.cnt = in_last ? 2'd2 : 2'd0;
                end
                else
                begin
                    entry.cnt = b_pct_wait ? 2'd1 : 2'd2;
                end
            end
            default:
            begin
                if (b_hex)
                begin
                    entry.data[0] = decoded;
                    entry.cnt     = 2'd1;
                end
                else
                begin
                    entry.data[0] = PDS_PCT_CHAR;
                    entry.data[1] = digit_reg;
                    entry.data[2] = in_byte;
                    entry.cnt     = b_pct_wait ? 2'd2 : 2'd3;
                end
            end
        endcase
    end

    assign push = accept && (entry.cnt != 2'd0);

endmodule

`default_nettype wire

>>> sv/pds_fifo.sv
// short queue of byte groups between front and back
`default_nettype none

module pds_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire pds_pkg::pds_entry_t wr_entry,
    input  wire logic               pop,
    output pds_pkg::pds_entry_t     rd_entry,
    output logic                    not_empty,
    output logic                    not_full
);
    import pds_pkg::*;

    pds_entry_t               store_reg [PDS_FIFO_DEPTH];
    logic [PDS_PTR_W-1:0]     wr_ptr_reg;
    logic [PDS_PTR_W-1:0]     rd_ptr_reg;
    logic [PDS_CNT_W-1:0]     count_reg;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != PDS_CNT_W'(PDS_FIFO_DEPTH));
    assign rd_entry  = store_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

>>> sv/pds_back.sv
// back part: sends the bytes of each group out one item per cycle while out_ready is high
`default_nettype none

module pds_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pds_pkg::pds_entry_t q_entry,
    input  wire logic               q_valid,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_byte,
    output logic                    run_last,
    output logic                    string_end
);
    import pds_pkg::*;

    logic                   valid_reg;
    pds_entry_t             cur_reg;
    logic [PDS_IDX_W-1:0]   idx_reg;
    logic                   at_end;
    logic                   done;

    assign at_end = (idx_reg == cur_reg.cnt - 1'b1);
    assign done   = valid_reg && out_ready && at_end;
    assign q_pop  = q_valid && (!valid_reg || done);

    // group and position control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (done)
        begin
            valid_reg <= 1'b0;
        end
        else if (valid_reg && out_ready)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // current group payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_entry;
        end
    end

    // output fields
    assign out_valid  = valid_reg;
    assign out_byte   = cur_reg.data[idx_reg];
    assign run_last   = at_end;
    assign string_end = at_end && cur_reg.last;

endmodule

`default_nettype wire

>>> sv/percent_decoder_stream_core.sv
// Streaming URL percent decoder.
// Input channel s_*: one raw byte of the escaped string per item in s_tdata,
// s_tlast marks the final byte of the string.
// Output channel m_*: one decoded byte per item in m_tdata, m_tuser[0] marks the
// last byte caused by one input item, m_tlast marks the final byte of the string.
// A '%' and two hex digits become one byte; a '%' that cannot complete is passed
// through as written, and the bytes after it are looked at again.
// Each input item gives zero to three output items. The front classifies an item in
// the cycle it is accepted and writes a non-empty byte group to a four-entry queue;
// the back loads each group from the queue into its output register and sends one
// byte per cycle while m_tready is high. Input is taken every cycle while the queue
// has room; sustained rate is one output byte per cycle, set by the single output
// port, so items that expand to two or three bytes slow the input once the queue
// fills. Reset clears the held '%' state, the queue and the output stage; no pass
// over storage is needed. When m_tready is low the current byte holds on m_tdata
// and the front keeps accepting until the queue is full, then s_tready falls.
`default_nettype none

module percent_decoder_stream_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte[7:0]
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte[7:0]
    output logic            m_tlast,
    output logic [0:0]      m_tuser    // run_last[0]
);
    import pds_pkg::*;

    logic       accept;
    logic       push;
    pds_entry_t front_entry;
    pds_entry_t q_entry;
    logic       q_valid;
    logic       q_room;
    logic       q_pop;
    logic       run_last;

    assign s_tready = q_room;
    assign accept   = s_tvalid && q_room;

    pds_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .push    (push),
        .entry   (front_entry)
    );

    pds_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_entry  (front_entry),
        .pop       (q_pop),
        .rd_entry  (q_entry),
        .not_empty (q_valid),
        .not_full  (q_room)
    );

    pds_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_entry    (q_entry),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .run_last   (run_last),
        .string_end (m_tlast)
    );

    assign m_tuser = run_last;

endmodule

`default_nettype wire

>>> sv/pds_checker.sv
// port-level checks for the percent decoder stream core
`default_nettype none

module pds_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic [0:0] m_tuser
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("output item changed while stalled");

    // end of string is always the end of a run
    a_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("string end outside run end");

    // bytes of one run leave back to back
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tuser[0] |=> m_tvalid)
        else $error("gap inside a run");

    // a string end taken in a handshake is also the end of a run
    a_end_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |-> m_tuser[0] && m_tvalid)
        else $error("string end handshake malformed");

endmodule

bind percent_decoder_stream_core pds_checker u_pds_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
